// ===== sv/wcd_pkg.sv =====
// Package for the windowed complex demodulator.
// Holds payload structs, register indexes, controller states, command and status
// structs and the fixed-point constants; every module imports it.
package wcd_pkg;

  // Field widths and window geometry
  localparam int SAMPLE_BITS    = 16;
  localparam int PHASE_BITS     = 16;
  localparam int MAX_HALF_WIDTH = 63;
  localparam int HALF_W         = 6;
  localparam int FREQ_W         = 16;
  localparam int OUT_W          = 24;
  localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1;
  localparam int ADDR_W         = $clog2(WIN_DEPTH);
  localparam int MEM_DEPTH      = 1 << ADDR_W;
  localparam int CNT_W          = $clog2(WIN_DEPTH + 1);
  localparam int TAP_W          = HALF_W + 1;
  localparam int TRIG_W         = 18;
  localparam int PROD_W         = SAMPLE_BITS + TRIG_W;
  localparam int ACC_W          = PROD_W + CNT_W;
  localparam int QUO_W          = ACC_W - 8;

  // Quarter turn in the phase domain
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  // Configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FREQUENCY  = 1'd1;
  localparam int CFG_W = 16;

  // Quarter-wave sine polynomial, Q30
  localparam logic signed [31:0] Q30 = 32'sd1073741824;
  localparam logic signed [31:0] C1  = 32'sd1686629713;
  localparam logic signed [31:0] C3  = -32'sd693598700;
  localparam logic signed [31:0] C5  = 32'sd85569300;
  localparam logic signed [31:0] C7  = -32'sd5026996;
  localparam logic signed [31:0] C9  = 32'sd172272;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          present;
    logic                          last_sample;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] real_part;
    logic signed [OUT_W-1:0] imag_part;
    logic                    empty_window;
    logic                    last_result;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SETUP, ST_TAP_INIT, ST_TAP_READ, ST_TAP_CHECK,
    ST_COS_GO, ST_COS_WAIT, ST_SIN_GO, ST_SIN_WAIT, ST_MAC_MUL, ST_MAC_ACC,
    ST_TAP_NEXT, ST_DIV_RE_GO, ST_DIV_RE_WAIT, ST_DIV_IM_GO, ST_DIV_IM_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic write;
    logic setup;
    logic tap_init;
    logic tap_read;
    logic trig_start;
    logic trig_cos;
    logic cap_cos;
    logic cap_sin;
    logic mac_mul;
    logic mac_acc;
    logic tap_next;
    logic div_start;
    logic div_im;
    logic cap_re;
    logic cap_im;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic emit_any;
    logic tap_use;
    logic tap_last;
    logic empty;
    logic trig_done;
    logic div_done;
    logic out_free;
    logic center_more;
  } status_t;

  // Map a 16-bit cycle fraction onto PHASE_BITS bits
  function automatic logic [PHASE_BITS-1:0] scale_phase(input logic [15:0] ph);
    logic [39:0] w;
    w = 40'(ph) << 24;
    return w[39 -: PHASE_BITS];
  endfunction

endpackage

// ===== sv/wcd_sine.sv =====
// Sequential quarter-wave sine unit: degree-9 odd polynomial evaluated by
// Horner's rule on one multiplier. Depends on wcd_pkg.
module wcd_sine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [wcd_pkg::PHASE_BITS-1:0]      phase_i,
  output logic                                done_o,
  output logic signed [wcd_pkg::TRIG_W-1:0]   value_o
);
  import wcd_pkg::*;

  localparam logic [3:0] K_SQUARE = 4'd0;
  localparam logic [3:0] K_X2     = 4'd1;
  localparam logic [3:0] K_C9     = 4'd2;
  localparam logic [3:0] K_C7     = 4'd3;
  localparam logic [3:0] K_C5     = 4'd5;
  localparam logic [3:0] K_C3     = 4'd7;
  localparam logic [3:0] K_C1     = 4'd9;
  localparam logic [3:0] K_LAST_M = 4'd10;
  localparam logic [3:0] K_ROUND  = 4'd11;

  logic                    busy_q;
  logic [3:0]              k_q;
  logic signed [31:0]      x_q, x2_q, p_q;
  logic signed [63:0]      prod_q;
  logic                    neg_q;
  logic signed [TRIG_W-1:0] val_q;
  logic                    done_q;

  logic signed [31:0]      x_start;
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      mul_p;
  logic signed [31:0]      coef;
  logic signed [31:0]      s_trunc;
  logic [32:0]             s_rnd;
  logic [TRIG_W-1:0]       s_mag;

  // Divide by 2^30 truncating toward zero
  function automatic logic signed [31:0] trunc30(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = m >> 30;
    return v[63] ? -signed'(m[31:0]) : signed'(m[31:0]);
  endfunction

  // Fold the phase into the first quadrant
  always_comb begin
    x_start = signed'(32'(phase_i[PHASE_BITS-3:0])) <<< (32 - PHASE_BITS);
    if (phase_i[PHASE_BITS-2]) x_start = Q30 - x_start;
  end

  // Select multiplier operands and Horner coefficient
  always_comb begin
    mul_a = p_q;
    mul_b = x2_q;
    coef  = C1;
    case (k_q)
      K_SQUARE: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      K_C9: mul_a = C9;
      K_LAST_M: mul_b = x_q;
      default: ;
    endcase
    case (k_q)
      K_C7:    coef = C7;
      K_C5:    coef = C5;
      K_C3:    coef = C3;
      default: coef = C1;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Round the Q30 result to Q16 and limit
  always_comb begin
    s_trunc = trunc30(prod_q);
    s_rnd   = s_trunc[31] ? 33'd0 : (33'(s_trunc) + 33'd8192) >> 14;
    s_mag   = (s_rnd > 33'd65536) ? TRIG_W'(65536) : s_rnd[TRIG_W-1:0];
  end

  // Step through square, Horner steps and final product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= K_SQUARE;
      end else if (busy_q) begin
        k_q <= k_q + 4'd1;
        if (k_q == K_ROUND) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_start;
      neg_q <= phase_i[PHASE_BITS-1];
    end else if (busy_q) begin
      case (k_q) inside
        K_X2:    x2_q <= signed'(prod_q[61:30]);
        K_C7, K_C5, K_C3, K_C1: p_q <= coef + trunc30(prod_q);
        K_ROUND: val_q <= neg_q ? -signed'(s_mag) : signed'(s_mag);
        default: prod_q <= mul_p;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = val_q;

endmodule

// ===== sv/wcd_div.sv =====
// Restoring divider: rounds the magnitude of a sum by 256*n and divides by n,
// one quotient bit a cycle. Depends on wcd_pkg.
module wcd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wcd_pkg::ACC_W-1:0]   mag_i,
  input  logic [wcd_pkg::CNT_W-1:0]   count_i,
  output logic                        done_o,
  output logic [wcd_pkg::QUO_W-1:0]   quo_o
);
  import wcd_pkg::*;

  localparam int STEP_W = $clog2(QUO_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [QUO_W-1:0]  t_q;
  logic [CNT_W-1:0]  d_q;
  logic [CNT_W:0]    rem_q;

  logic [ACC_W:0]    biased;
  logic [CNT_W:0]    shifted;
  logic              ge;

  // Add half the divisor, drop the eight fraction bits, then take one bit a step
  always_comb begin
    biased  = {1'b0, mag_i} + ((ACC_W + 1)'(count_i) << 7);
    shifted = {rem_q[CNT_W-1:0], t_q[QUO_W-1]};
    ge      = shifted >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q   <= biased[ACC_W-1:8];
      d_q   <= count_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? shifted - {1'b0, d_q} : shifted;
      t_q   <= {t_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = t_q;

endmodule

// ===== sv/wcd_ctrl.sv =====
// Controller of the demodulator: sequences centers, taps, trig evaluation,
// accumulation, division and the result request. Depends on wcd_pkg.
module wcd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wcd_pkg::status_t status_i,
  output wcd_pkg::cmd_t    cmd_o
);
  import wcd_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP:     state_d = status_i.emit_any ? ST_TAP_INIT : ST_IDLE;
      ST_TAP_INIT:  state_d = ST_TAP_READ;
      ST_TAP_READ:  state_d = ST_TAP_CHECK;
      ST_TAP_CHECK: state_d = status_i.tap_use ? ST_COS_GO : ST_TAP_NEXT;
      ST_COS_GO:    state_d = ST_COS_WAIT;
      ST_COS_WAIT:  if (status_i.trig_done) state_d = ST_SIN_GO;
      ST_SIN_GO:    state_d = ST_SIN_WAIT;
      ST_SIN_WAIT:  if (status_i.trig_done) state_d = ST_MAC_MUL;
      ST_MAC_MUL:   state_d = ST_MAC_ACC;
      ST_MAC_ACC:   state_d = ST_TAP_NEXT;
      ST_TAP_NEXT: begin
        if (!status_i.tap_last)    state_d = ST_TAP_READ;
        else if (status_i.empty)   state_d = ST_EMIT;
        else                       state_d = ST_DIV_RE_GO;
      end
      ST_DIV_RE_GO:   state_d = ST_DIV_RE_WAIT;
      ST_DIV_RE_WAIT: if (status_i.div_done) state_d = ST_DIV_IM_GO;
      ST_DIV_IM_GO:   state_d = ST_DIV_IM_WAIT;
      ST_DIV_IM_WAIT: if (status_i.div_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) state_d = status_i.center_more ? ST_TAP_INIT : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.write = in_valid_i;
      end
      ST_SETUP:     cmd_o.setup    = 1'b1;
      ST_TAP_INIT:  cmd_o.tap_init = 1'b1;
      ST_TAP_READ:  cmd_o.tap_read = 1'b1;
      ST_COS_GO: begin
        cmd_o.trig_start = 1'b1;
        cmd_o.trig_cos   = 1'b1;
      end
      ST_COS_WAIT:  cmd_o.cap_cos    = status_i.trig_done;
      ST_SIN_GO:    cmd_o.trig_start = 1'b1;
      ST_SIN_WAIT:  cmd_o.cap_sin    = status_i.trig_done;
      ST_MAC_MUL:   cmd_o.mac_mul    = 1'b1;
      ST_MAC_ACC:   cmd_o.mac_acc    = 1'b1;
      ST_TAP_NEXT:  cmd_o.tap_next   = 1'b1;
      ST_DIV_RE_GO: cmd_o.div_start  = 1'b1;
      ST_DIV_RE_WAIT: cmd_o.cap_re   = status_i.div_done;
      ST_DIV_IM_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_im    = 1'b1;
      end
      ST_DIV_IM_WAIT: begin
        cmd_o.div_im = 1'b1;
        cmd_o.cap_im = status_i.div_done;
      end
      ST_EMIT:      cmd_o.emit = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== sv/wcd_dp.sv =====
// Datapath of the demodulator: sample window memory, configuration, tap
// indexing, complex multiply-accumulate, scaling and the result register.
// Depends on wcd_pkg, wcd_sine and wcd_div.
module wcd_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wcd_pkg::in_t                 in_data_i,
  input  logic                         cfg_we_i,
  input  logic [wcd_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [wcd_pkg::CFG_W-1:0]    cfg_data_i,
  input  wcd_pkg::cmd_t                cmd_i,
  output wcd_pkg::status_t             status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output wcd_pkg::out_t                out_data_o
);
  import wcd_pkg::*;

  // Configuration
  logic [HALF_W-1:0] half_q;
  logic [FREQ_W-1:0] freq_q;

  // Window and indexing
  logic [SAMPLE_BITS:0]   mem_q [MEM_DEPTH];
  logic [SAMPLE_BITS:0]   rd_q;
  logic                   ok_q;
  logic [ADDR_W-1:0]      wp_q;
  logic [CNT_W-1:0]       fill_q;
  logic                   last_q;
  logic [HALF_W-1:0]      center_q;
  logic signed [TAP_W-1:0] j_q;
  logic [15:0]            phase_q;
  logic [CNT_W-1:0]       n_q;

  // Arithmetic
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic signed [PROD_W-1:0] pre_q, pim_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
  logic [OUT_W-1:0]         re_q, im_q;
  out_t                     out_q;
  logic                     out_valid_q;

  logic signed [TAP_W:0]    pos;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     tap_ok;
  logic [CNT_W-1:0]         fill_m1;
  logic [21:0]              fh;
  logic [PHASE_BITS-1:0]    trig_phase;
  logic                     trig_done;
  logic signed [TRIG_W-1:0] trig_val;
  logic [ACC_W-1:0]         div_mag;
  logic                     div_done;
  logic [QUO_W-1:0]         div_quo;
  logic                     out_free;

  // Clamp a quotient into the signed output range
  function automatic logic [OUT_W-1:0] sat_out(input logic [QUO_W-1:0] q, input logic neg);
    logic [QUO_W-1:0] m;
    m = q;
    if (neg) begin
      if (m > QUO_W'(1 << (OUT_W - 1))) m = QUO_W'(1 << (OUT_W - 1));
      return OUT_W'(QUO_W'(0) - m);
    end else begin
      if (m > QUO_W'((1 << (OUT_W - 1)) - 1)) m = QUO_W'((1 << (OUT_W - 1)) - 1);
      return m[OUT_W-1:0];
    end
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= '0;
      freq_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HALF_WIDTH: half_q <= cfg_data_i[HALF_W-1:0];
        REG_FREQUENCY:  freq_q <= cfg_data_i[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Tap position relative to the newest sample, and its address
  always_comb begin
    pos     = (TAP_W + 1)'({2'b00, center_q}) - {j_q[TAP_W-1], j_q};
    tap_ok  = !pos[TAP_W] && (pos[ADDR_W-1:0] < fill_q);
    rd_addr = wp_q - ADDR_W'(1) - pos[ADDR_W-1:0];
    fill_m1 = fill_q - CNT_W'(1);
    fh      = freq_q * half_q;
    trig_phase = scale_phase(phase_q) + (cmd_i.trig_cos ? QUARTER : '0);
    div_mag = cmd_i.div_im ? (acc_im_q[ACC_W-1] ? ACC_W'(-acc_im_q) : ACC_W'(acc_im_q))
                           : (acc_re_q[ACC_W-1] ? ACC_W'(-acc_re_q) : ACC_W'(acc_re_q));
    out_free = !out_valid_q || out_ready_i;
  end

  // Window memory: write the new sample, read one tap a request
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem_q[wp_q] <= {in_data_i.present, in_data_i.present ? in_data_i.sample : '0};
    end
    if (cmd_i.tap_read) rd_q <= mem_q[rd_addr];
  end

  // Series and tap control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      fill_q   <= '0;
      last_q   <= 1'b0;
      center_q <= '0;
      j_q      <= '0;
      phase_q  <= '0;
      n_q      <= '0;
      ok_q     <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        wp_q   <= wp_q + ADDR_W'(1);
        last_q <= in_data_i.last_sample;
        if (fill_q != CNT_W'(WIN_DEPTH)) fill_q <= fill_q + CNT_W'(1);
      end
      if (cmd_i.setup) begin
        if (last_q && (fill_m1 <= CNT_W'(half_q))) center_q <= fill_m1[HALF_W-1:0];
        else                                       center_q <= half_q;
      end
      if (cmd_i.tap_init) begin
        j_q     <= -signed'({1'b0, half_q});
        phase_q <= 16'd0 - fh[15:0];
        n_q     <= '0;
      end
      if (cmd_i.tap_read) ok_q <= tap_ok;
      if (cmd_i.mac_acc) n_q <= n_q + CNT_W'(1);
      if (cmd_i.tap_next) begin
        j_q     <= j_q + TAP_W'(1);
        phase_q <= phase_q + freq_q;
      end
      // Step to the next center of a flush; close the series after the final one
      if (cmd_i.emit && last_q) begin
        if (center_q != '0) center_q <= center_q - HALF_W'(1);
        else                fill_q   <= '0;
      end
    end
  end

  // Multiply-accumulate and scaled results
  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_init) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end
    if (cmd_i.cap_cos) cos_q <= trig_val;
    if (cmd_i.cap_sin) sin_q <= trig_val;
    if (cmd_i.mac_mul) begin
      pre_q <= signed'(rd_q[SAMPLE_BITS-1:0]) * cos_q;
      pim_q <= signed'(rd_q[SAMPLE_BITS-1:0]) * sin_q;
    end
    if (cmd_i.mac_acc) begin
      acc_re_q <= acc_re_q + ACC_W'(pre_q);
      acc_im_q <= acc_im_q - ACC_W'(pim_q);
    end
    if (cmd_i.cap_re) re_q <= sat_out(div_quo, acc_re_q[ACC_W-1]);
    if (cmd_i.cap_im) im_q <= sat_out(div_quo, acc_im_q[ACC_W-1]);
    if (cmd_i.emit) begin
      out_q.real_part    <= (n_q == '0) ? '0 : signed'(re_q);
      out_q.imag_part    <= (n_q == '0) ? '0 : signed'(im_q);
      out_q.empty_window <= (n_q == '0);
      out_q.last_result  <= last_q && (center_q == '0);
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (cmd_i.emit)  out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  wcd_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.trig_start),
    .phase_i (trig_phase),
    .done_o  (trig_done),
    .value_o (trig_val)
  );

  wcd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .mag_i   (div_mag),
    .count_i (n_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Status to the controller
  always_comb begin
    status_o.emit_any    = last_q || (fill_q > CNT_W'(half_q));
    status_o.tap_use     = ok_q && rd_q[SAMPLE_BITS];
    status_o.tap_last    = (j_q == signed'({1'b0, half_q}));
    status_o.empty       = (n_q == '0);
    status_o.trig_done   = trig_done;
    status_o.div_done    = div_done;
    status_o.out_free    = out_free;
    status_o.center_more = last_q && (center_q != '0);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free) else $error("result loaded over a pending request");
  a_fill_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |=> fill_q != '0) else $error("fill count zero after write");
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tap_next |-> j_q <= signed'({1'b0, half_q})) else $error("tap beyond half width");
  a_div_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> n_q != '0) else $error("division by an empty count");

endmodule

// ===== sv/windowed_complex_demodulator_top.sv =====
// Windowed complex demodulator, top level.
// Input channel in_valid_i/in_ready_o carries one sample per time tick with a
// present flag and a last_sample mark. Output channel out_valid_o/out_ready_i
// carries averaged real and imaginary parts, an empty flag and a last mark.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 half width, 1 frequency) in the same cycle. The user must write only while
// the block is idle; the block itself does not enforce this. One request is
// taken at a time. Each emitted center walks 2h+1 window taps; a present tap
// runs two sine evaluations on the shared polynomial multiplier, cosine then
// sine, followed by the complex multiply-accumulate, while a missing or clipped
// tap is skipped. Unless the window is empty, both averages then pass the
// one-bit-a-cycle divider, real part first. A request that emits nothing
// returns straight to idle, and a last_sample request emits up to h+1 centers
// back to back.
// The result sits in an output register; while it is stalled the next center
// waits in the emit step and input stays blocked.
// Reset clears configuration, fill count and output valid; the window memory
// needs no clearing since taps beyond the fill count are ignored.
// Depends on wcd_pkg, wcd_ctrl and wcd_dp.
module windowed_complex_demodulator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wcd_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wcd_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [wcd_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [wcd_pkg::CFG_W-1:0]     cfg_data_i
);
  import wcd_pkg::*;

  cmd_t    cmd;
  status_t status;

  wcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb_windowed_complex_demodulator_top.sv =====
// Testbench for the windowed complex demodulator top level.
// Holds a self-checking bench with its own predictor; depends on wcd_pkg and
// windowed_complex_demodulator_top.
`timescale 1ns / 100ps

module tb_windowed_complex_demodulator_top;
  import wcd_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 3000;
  localparam longint SIN_Q30    = 64'sd1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index_i = REG_HALF_WIDTH;
  logic [CFG_W-1:0] cfg_data_i = '0;

  // Stimulus queues, idle settings and checking state
  in_t pending_q[$];
  out_t demod_expect_q[$];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;

  // Predictor state: window of taps, newest at index 0
  longint tap_val[WIN_DEPTH];
  bit tap_ok[WIN_DEPTH];
  int ticks_seen = 0;
  int pred_half = 0;
  int pred_freq = 0;

  windowed_complex_demodulator_top i_dut (.*);

  always #4 clk_i = ~clk_i;

  // Quarter-wave sine in Q16 from a Q30 quadrant fraction
  function automatic longint quarter_sine(longint x);
    longint x2, p, s;
    x2 = x * x / SIN_Q30;
    p = 64'sd172272;
    p = -64'sd5026996 + p * x2 / SIN_Q30;
    p = 64'sd85569300 + p * x2 / SIN_Q30;
    p = -64'sd693598700 + p * x2 / SIN_Q30;
    p = 64'sd1686629713 + p * x2 / SIN_Q30;
    s = p * x / SIN_Q30;
    if (s < 0) s = 0;
    s = (s + 8192) / 16384;
    if (s > 65536) s = 65536;
    return s;
  endfunction

  function automatic longint phase_sine(logic [15:0] ph);
    longint x, v;
    x = longint'(ph[13:0]) <<< 16;
    if (ph[14]) x = SIN_Q30 - x;
    v = quarter_sine(x);
    return ph[15] ? -v : v;
  endfunction

  // Rounded mean with 8 fraction bits, saturated to the output width
  function automatic logic [OUT_W-1:0] mean_q8(longint sum, int n);
    longint mag, d, q;
    mag = (sum < 0) ? -sum : sum;
    d = longint'(n) * 256;
    q = (mag + d / 2) / d;
    if (sum < 0) begin
      if (q > 8388608) q = 8388608;
      q = -q;
    end else if (q > 8388607) begin
      q = 8388607;
    end
    return q[OUT_W-1:0];
  endfunction

  // Demodulate one center and queue the expected result
  function automatic void demod_center(int center, int h, bit is_last);
    longint re, im;
    int n, pos;
    logic [31:0] prod;
    logic [15:0] ph;
    out_t r;
    re = 0;
    im = 0;
    n = 0;
    for (int j = -h; j <= h; j++) begin
      pos = center - j;
      if (pos < 0 || pos >= WIN_DEPTH) continue;
      if (!tap_ok[pos]) continue;
      prod = 32'(pred_freq) * 32'(j);
      ph = prod[15:0];
      re += tap_val[pos] * phase_sine(ph + 16'h4000);
      im -= tap_val[pos] * phase_sine(ph);
      n++;
    end
    r = '0;
    if (n > 0) begin
      r.real_part = mean_q8(re, n);
      r.imag_part = mean_q8(im, n);
    end else begin
      r.empty_window = 1'b1;
    end
    r.last_result = is_last;
    demod_expect_q.push_back(r);
  endfunction

  // Shift in one tick and work out the centers it completes
  function automatic void demod_tick(in_t it);
    int h, top;
    h = (pred_half > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : pred_half;
    for (int k = WIN_DEPTH - 1; k > 0; k--) begin
      tap_val[k] = tap_val[k-1];
      tap_ok[k] = tap_ok[k-1];
    end
    tap_ok[0] = it.present;
    tap_val[0] = it.present ? longint'($signed(it.sample)) : 0;
    if (ticks_seen < WIN_DEPTH) ticks_seen++;
    if (!it.last_sample) begin
      if (ticks_seen > h) demod_center(h, h, 1'b0);
    end else begin
      top = (ticks_seen - 1 > h) ? h : ticks_seen - 1;
      for (int c = top; c >= 0; c--) demod_center(c, h, c == 0);
      for (int k = 0; k < WIN_DEPTH; k++) begin
        tap_ok[k] = 1'b0;
        tap_val[k] = 0;
      end
      ticks_seen = 0;
    end
  endfunction

  // Drive requests from the pending queue, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data_i <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive ready with random stalls and the occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Track configuration, predict on input, check on output, watch for hangs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_HALF_WIDTH) pred_half = int'(cfg_data_i[HALF_W-1:0]);
        else if (cfg_index_i == REG_FREQUENCY) pred_freq = int'(cfg_data_i[FREQ_W-1:0]);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        demod_tick(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (demod_expect_q.size() == 0) begin
          $error("unexpected result %p", out_data_o);
          err_cnt++;
        end else begin
          out_t e;
          e = demod_expect_q.pop_front();
          if (out_data_o.real_part !== e.real_part) begin
            $error("real_part exp %0d got %0d", e.real_part, out_data_o.real_part);
            err_cnt++;
          end
          if (out_data_o.imag_part !== e.imag_part) begin
            $error("imag_part exp %0d got %0d", e.imag_part, out_data_o.imag_part);
            err_cnt++;
          end
          if (out_data_o.empty_window !== e.empty_window) begin
            $error("empty_window exp %0b got %0b", e.empty_window,
                   out_data_o.empty_window);
            err_cnt++;
          end
          if (out_data_o.last_result !== e.last_result) begin
            $error("last_result exp %0b got %0b", e.last_result, out_data_o.last_result);
            err_cnt++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Wait until every request is taken and every result is back
  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() > 0 || in_valid_i || demod_expect_q.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_tick(int value, bit pres, bit fin);
    in_t it;
    it.sample = SAMPLE_BITS'(value);
    it.present = pres;
    it.last_sample = fin;
    pending_q.push_back(it);
  endtask

  // Queue a series of random ticks; optionally leave it open
  task automatic push_series(int len, int pres_pct, bit close_it);
    for (int k = 0; k < len; k++)
      push_tick($urandom_range(65535), $urandom_range(99) < pres_pct,
                close_it && k == len - 1);
  endtask

  initial begin
    int h, len;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      tap_ok[k] = 1'b0;
      tap_val[k] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, gaps, empty windows, one-tick series
    write_reg(REG_HALF_WIDTH, 2);
    write_reg(REG_FREQUENCY, 16'h1000);
    push_tick(32767, 1, 0);
    push_tick(-32768, 1, 0);
    push_tick(0, 0, 0);
    push_tick(-1, 1, 0);
    push_tick(32767, 1, 1);
    push_tick(-32768, 1, 1);
    for (int k = 0; k < 4; k++) push_tick(-32768, 0, k == 3);
    drain();
    write_reg(REG_HALF_WIDTH, 0);
    write_reg(REG_FREQUENCY, 65535);
    push_tick(-32768, 1, 0);
    push_tick(32767, 0, 0);
    push_tick(12345, 1, 1);
    drain();
    write_reg(REG_HALF_WIDTH, 63);
    write_reg(REG_FREQUENCY, 16'h8000);
    push_tick(-32768, 1, 0);
    push_tick(-32768, 1, 0);
    push_tick(32767, 1, 1);
    push_tick(5, 0, 1);
    drain();

    // Random phases, cycling through the idle patterns
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
        default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
      endcase
      h = (ph == 5) ? 63 : (($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(3));
      write_reg(REG_HALF_WIDTH, h);
      write_reg(REG_FREQUENCY, (ph == 3) ? 0 : $urandom_range(65535));
      for (int n = 0; n < 26; n += len) begin
        len = (h == 63) ? $urandom_range(1, 5) : $urandom_range(1, 20);
        push_series(len, ($urandom_range(3) == 0) ? 30 : 85, $urandom_range(4) != 0);
      end
      // Hold the receiver off so the block backs up
      if (ph == 8) hold_seq++;
      drain();
    end

    // Long sparse series at the widest window
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_reg(REG_HALF_WIDTH, 63);
    write_reg(REG_FREQUENCY, $urandom_range(65535));
    push_series(70, 20, 1);
    drain();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wcd_pkg.sv
sv/wcd_sine.sv
sv/wcd_div.sv
sv/wcd_ctrl.sv
sv/wcd_dp.sv
sv/windowed_complex_demodulator_top.sv
test/tb_windowed_complex_demodulator_top.sv
